// ===== src/prcc_pkg.sv =====
`default_nettype none

package prcc_pkg;

    localparam int PAL_ENTRIES = 4096;
    localparam int ENTRY_W     = $clog2(PAL_ENTRIES);
    localparam int ADDR_W      = 13;
    localparam int PIX_W       = 14;
    localparam int NUM_BANKS   = 4;
    localparam int ROW_W       = ADDR_W - 2;
    localparam int BANK_ROWS   = 1 << ROW_W;

    localparam logic [PIX_W-1:0] PIX_MASK = PIX_W'(3 * PAL_ENTRIES - 1);

    localparam logic [1:0] KIND_READ   = 2'd0;
    localparam logic [1:0] KIND_WRITE  = 2'd1;
    localparam logic [1:0] KIND_LOOKUP = 2'd2;

    localparam logic [1:0] SIZE_BYTE = 2'd0;
    localparam logic [1:0] SIZE_WORD = 2'd1;
    localparam logic [1:0] SIZE_LONG = 2'd2;

    localparam logic [1:0] CFG_RED_SHIFT   = 2'd0;
    localparam logic [1:0] CFG_GREEN_SHIFT = 2'd1;
    localparam logic [1:0] CFG_BLUE_SHIFT  = 2'd2;

    typedef struct packed {
        logic [1:0]        kind;
        logic [1:0]        access_size;
        logic [ADDR_W-1:0] byte_address;
        logic [31:0]       write_data;
        logic [PIX_W-1:0]  pixel_index;
    } t_req;

    typedef struct packed {
        logic [31:0] read_data;
        logic [31:0] color_out;
    } t_rsp;

    typedef struct packed {
        logic [4:0] red;
        logic [4:0] green;
        logic [4:0] blue;
    } t_shifts;

    typedef logic [7:0] t_level_tab [64];

    // index {shadow, c5}: c5*255/31, shadow then *202/256
    function automatic t_level_tab build_levels();
        t_level_tab tab;
        int         full;
        for (int i = 0; i < 64; i++) begin
            full = ((i % 32) * 255) / 31;
            if (i >= 32) begin
                full = (full * 202) / 256;
            end
            tab[i] = 8'(full);
        end
        return tab;
    endfunction

    localparam t_level_tab LEVEL_TAB = build_levels();

endpackage

`default_nettype wire

// ===== src/prcc_color.sv =====
`default_nettype none

module prcc_color
    import prcc_pkg::*;
(
    input  wire logic [15:0] i_word,
    input  wire logic        i_shadow,
    input  wire t_shifts     i_shifts,
    output logic [31:0]      o_color
);

    logic [7:0] w_red;
    logic [7:0] w_green;
    logic [7:0] w_blue;

    assign w_red   = LEVEL_TAB[{i_shadow, i_word[3:0],  i_word[12]}];
    assign w_green = LEVEL_TAB[{i_shadow, i_word[7:4],  i_word[13]}];
    assign w_blue  = LEVEL_TAB[{i_shadow, i_word[11:8], i_word[14]}];

    assign o_color = (32'(w_red)   << i_shifts.red)
                   | (32'(w_green) << i_shifts.green)
                   | (32'(w_blue)  << i_shifts.blue);

endmodule

`default_nettype wire

// ===== src/palette_ram_color_converter.sv =====
// Channel   Direction  Payload  Handshake
// request   in         t_req    i_valid / o_stall
// response  out        t_rsp    o_valid / i_stall
//
// One request per cycle while o_stall is low; a read or lookup response comes from a
// bank read at the accepting edge, then color/byte assembly into the output register
// once the middle stage advances.
// Store is four byte-wide banks of 2048 rows, one write and one read per cycle each.
// After reset a clearing pass zeroes one row of every bank per cycle, holding o_stall
// high until all 2048 rows are clear. Config writes are taken at any time.
// A held response stalls the middle stage, and then the request side.
`default_nettype none

module palette_ram_color_converter
    import prcc_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_stall,
    input  wire t_req       i_req,
    output logic            o_valid,
    input  wire logic       i_stall,
    output t_rsp            o_rsp,
    input  wire logic       i_cfg_we,
    input  wire logic [1:0] i_cfg_index,
    input  wire logic [4:0] i_cfg_data
);

    t_shifts           r_shifts;
    logic              r_clearing;
    logic [ROW_W-1:0]  r_clr_row;

    logic              r_s1_valid;
    logic              r_s1_lookup;
    logic              r_s1_shadow;
    logic [1:0]        r_s1_size;
    logic [1:0]        r_s1_alo;
    logic [7:0]        r_rd [NUM_BANKS];

    logic              r_out_valid;
    t_rsp              r_rsp;

    logic              w_accept;
    logic              w_advance;
    logic              w_is_lookup;
    logic              w_is_read;
    logic              w_is_write;
    logic [PIX_W-1:0]  w_idx;
    logic [ENTRY_W-1:0] w_entry;
    logic              w_shadow;
    logic [ADDR_W-1:0] w_addr;
    logic [1:0]        w_size;
    logic [1:0]        w_last;
    logic [1:0]        w_off [NUM_BANKS];
    logic [ADDR_W-1:0] w_sum [NUM_BANKS];
    logic [ROW_W-1:0]  w_row [NUM_BANKS];
    logic              w_we [NUM_BANKS];
    logic [7:0]        w_wd [NUM_BANKS];
    logic [7:0]        w_b [NUM_BANKS];
    logic [31:0]       w_color;
    t_rsp              w_rsp;

    assign w_advance   = r_s1_valid && (!r_out_valid || !i_stall);
    assign o_stall     = r_clearing || (r_s1_valid && !w_advance);
    assign w_accept    = i_valid && !o_stall;
    assign w_is_lookup = i_req.kind == KIND_LOOKUP;
    assign w_is_read   = i_req.kind == KIND_READ;
    assign w_is_write  = i_req.kind == KIND_WRITE;

    always_comb begin
        w_idx    = i_req.pixel_index & PIX_MASK;
        w_shadow = w_idx >= PIX_W'(PAL_ENTRIES);
        if (w_idx >= PIX_W'(2 * PAL_ENTRIES)) begin
            w_entry = ENTRY_W'(w_idx - PIX_W'(2 * PAL_ENTRIES));
        end else if (w_shadow) begin
            w_entry = ENTRY_W'(w_idx - PIX_W'(PAL_ENTRIES));
        end else begin
            w_entry = ENTRY_W'(w_idx);
        end
        if (w_is_lookup) begin
            w_addr = ADDR_W'({w_entry, 1'b0});
            w_size = SIZE_WORD;
        end else begin
            w_addr = i_req.byte_address;
            w_size = i_req.access_size;
        end
        case (w_size)
            SIZE_BYTE: w_last = 2'd0;
            SIZE_WORD: w_last = 2'd1;
            default:   w_last = 2'd3;
        endcase
    end

    always_comb begin
        for (int k = 0; k < NUM_BANKS; k++) begin
            w_off[k] = 2'(k) - w_addr[1:0];
            w_sum[k] = w_addr + ADDR_W'(w_off[k]);
            w_row[k] = w_sum[k][ADDR_W-1:2];
            w_we[k]  = w_accept && w_is_write && (w_off[k] <= w_last);
            case (w_size)
                SIZE_BYTE: w_wd[k] = i_req.write_data[7:0];
                SIZE_WORD: w_wd[k] = w_off[k][0] ? i_req.write_data[7:0]
                                                 : i_req.write_data[15:8];
                default:   w_wd[k] = 8'(i_req.write_data >> {2'd3 - w_off[k], 3'b000});
            endcase
        end
    end

    for (genvar k = 0; k < NUM_BANKS; k++) begin : g_bank
        logic [7:0]       mem [BANK_ROWS];
        logic             w_mem_we;
        logic [ROW_W-1:0] w_mem_row;
        logic [7:0]       w_mem_wd;

        assign w_mem_we  = r_clearing || w_we[k];
        assign w_mem_row = r_clearing ? r_clr_row : w_row[k];
        assign w_mem_wd  = r_clearing ? 8'h00 : w_wd[k];

        always_ff @(posedge i_clk) begin
            if (w_mem_we) begin
                mem[w_mem_row] <= w_mem_wd;
            end
            if (w_accept) begin
                r_rd[k] <= mem[w_row[k]];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_row  <= '0;
        end else if (r_clearing) begin
            r_clr_row <= r_clr_row + ROW_W'(1);
            if (r_clr_row == ROW_W'(BANK_ROWS - 1)) begin
                r_clearing <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shifts.red   <= 5'd16;
            r_shifts.green <= 5'd8;
            r_shifts.blue  <= 5'd0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_RED_SHIFT:   r_shifts.red   <= i_cfg_data;
                CFG_GREEN_SHIFT: r_shifts.green <= i_cfg_data;
                CFG_BLUE_SHIFT:  r_shifts.blue  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_accept && (w_is_read || w_is_lookup)) begin
            r_s1_valid <= 1'b1;
        end else if (w_advance) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_lookup <= w_is_lookup;
            r_s1_shadow <= w_shadow;
            r_s1_size   <= w_size;
            r_s1_alo    <= w_addr[1:0];
        end
    end

    always_comb begin
        for (int j = 0; j < NUM_BANKS; j++) begin
            w_b[j] = r_rd[2'(j) + r_s1_alo];
        end
    end

    prcc_color u_color (
        .i_word   ({w_b[0], w_b[1]}),
        .i_shadow (r_s1_shadow),
        .i_shifts (r_shifts),
        .o_color  (w_color)
    );

    always_comb begin
        w_rsp = '0;
        if (r_s1_lookup) begin
            w_rsp.color_out = w_color;
        end else begin
            case (r_s1_size)
                SIZE_BYTE: w_rsp.read_data = {24'd0, w_b[0]};
                SIZE_WORD: w_rsp.read_data = {16'd0, w_b[0], w_b[1]};
                default:   w_rsp.read_data = {w_b[0], w_b[1], w_b[2], w_b[3]};
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_rsp <= w_rsp;
        end
    end

    assign o_valid = r_out_valid;
    assign o_rsp   = r_rsp;

endmodule

`default_nettype wire

// ===== src/prcc_checker.sv =====
`default_nettype none

module prcc_checker
    import prcc_pkg::*;
(
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       o_stall,
    input wire logic       o_valid,
    input wire logic       i_stall,
    input wire t_rsp       o_rsp
);

    a_clear_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> o_stall)
        else $error("request side open right after reset");

    a_one_field_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_rsp.read_data == 32'd0 || o_rsp.color_out == 32'd0))
        else $error("response carries both read data and color");

    a_valid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid)
        else $error("response dropped while stalled");

    a_payload_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> $stable(o_rsp))
        else $error("response changed while stalled");

endmodule

bind palette_ram_color_converter prcc_checker u_prcc_checker (.*);

`default_nettype wire
